### src/crc_frc_pkg.sv
// Shared types and constants for the CRC-framed record checker.
// Holds result status codes, register indexes, the result struct and the CRC32C byte step.
// No dependencies.
package crc_frc_pkg;

  localparam int HDR_BYTES   = 16;
  localparam int HDR_BITS    = HDR_BYTES * 8;
  localparam int LEN_W       = 21;
  localparam int OUT_OFF_W   = 40;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [31:0] CRC_POLY      = 32'h82f6_3b78;
  localparam logic [31:0] CRC_INIT      = 32'hffff_ffff;
  localparam logic [31:0] MAGIC_RESET   = 32'h4c4c_4d44;
  localparam logic [31:0] VERSION_RESET = 32'h0000_0001;
  localparam logic [LEN_W-1:0] LEN_CAP  = LEN_W'(1 << 20);
  localparam logic [LEN_W-1:0] LEN_SAT  = '1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_HDR   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CRC_FAIL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TORN      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEAN_END = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_OFF_W-1:0] record_offset;
    logic [LEN_W-1:0]     body_length;
    logic [31:0]          computed_crc;
  } result_t;

  // reflected CRC32C, one byte, eight unrolled bit steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

### src/crc_frc_out_buf.sv
// Result output register with one skid entry for the record checker.
// Depends on crc_frc_pkg (result_t).
module crc_frc_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  crc_frc_pkg::result_t res,
  output logic                 skid_full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output crc_frc_pkg::result_t out_res
);

  logic                 out_valid_r;
  logic                 skid_valid_r;
  crc_frc_pkg::result_t out_res_r;
  crc_frc_pkg::result_t skid_res_r;
  logic                 out_fire;

  assign out_fire  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign skid_full = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // input is held off while the skid entry is occupied
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_res_r <= skid_res_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_res_r <= res;
      end else begin
        skid_res_r <= res;
      end
    end
  end

endmodule

### src/crc_framed_record_checker_core.sv
// CRC-framed record checker: top level with header parse, body CRC32C and config registers.
// Depends on crc_frc_pkg and crc_frc_out_buf.
//
// Takes one log byte (or an end-of-log marker) per beat and can accept a beat every cycle:
// the header shift register, the unrolled eight-bit CRC32C step and the header compares are
// all combinational, and a result lands in the output register at the edge that accepts the
// beat that causes it, or in the one skid entry if that register cannot drain. Input stalls
// only when two results are waiting. Each record is a 16-byte little-endian header (magic,
// version, body length, CRC32C) then the body; a bad header or CRC mismatch is reported once
// and the checker then ignores bytes until the next end-of-log beat, which always rearms it.
// The user must write configuration via cfg_we/cfg_index/cfg_wdata only while idle; unchecked.
module crc_framed_record_checker_core #(
  parameter int OFFSET_BITS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_log,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [39:0] out_record_offset,
  output logic [20:0] out_body_length,
  output logic [31:0] out_computed_crc,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int HB = crc_frc_pkg::HDR_BITS;
  localparam int LW = crc_frc_pkg::LEN_W;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_STOP   = 2'd2;

  // configuration
  logic [31:0]   magic_r;
  logic [31:0]   version_r;
  logic [LW-1:0] max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= crc_frc_pkg::MAGIC_RESET;
      version_r <= crc_frc_pkg::VERSION_RESET;
      max_len_r <= crc_frc_pkg::LEN_CAP;
    end else if (cfg_we) begin
      case (cfg_index)
        crc_frc_pkg::REG_MAGIC:   magic_r   <= cfg_wdata;
        crc_frc_pkg::REG_VERSION: version_r <= cfg_wdata;
        crc_frc_pkg::REG_MAX_LEN: max_len_r <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // scan state
  logic [1:0]             phase_r,     phase_nxt;
  logic [3:0]             hcnt_r,      hcnt_nxt;
  logic [HB-1:0]          hdr_r,       hdr_nxt;
  logic [31:0]            crc_r,       crc_nxt;
  logic [LW-1:0]          rem_r,       rem_nxt;
  logic [OFFSET_BITS-1:0] rec_start_r, rec_start_nxt;
  logic [OFFSET_BITS-1:0] pos_r,       pos_nxt;

  logic                 in_fire;
  logic                 skid_full;
  logic                 res_valid;
  crc_frc_pkg::result_t res;
  crc_frc_pkg::result_t out_res;

  logic [HB-1:0]   hdr_shift;
  logic [31:0]     hdr_len;
  logic [LW-1:0]   len_lim;
  logic            hdr_bad;
  logic [31:0]     crc_step;
  logic [31:0]     crc_fin;
  logic [63:0]     rec_start_ext;

  assign in_stall = skid_full;
  assign in_fire  = in_valid & ~skid_full;

  // bytes arrive little-endian; shifting in at the top leaves byte 0 at bit 0
  assign hdr_shift = {in_data_byte, hdr_r[HB-1:8]};
  assign hdr_len   = hdr_shift[95:64];
  assign len_lim   = (max_len_r < crc_frc_pkg::LEN_CAP) ? max_len_r : crc_frc_pkg::LEN_CAP;
  assign hdr_bad   = (hdr_shift[31:0] != magic_r) || (hdr_shift[63:32] != version_r) ||
                     (hdr_len == 32'd0) || (hdr_len > {11'd0, len_lim});
  assign crc_step  = crc_frc_pkg::crc_byte(crc_r, in_data_byte);
  assign crc_fin   = ~crc_step;
  assign rec_start_ext = 64'(rec_start_r);

  always_comb begin
    phase_nxt     = phase_r;
    hcnt_nxt      = hcnt_r;
    hdr_nxt       = hdr_r;
    crc_nxt       = crc_r;
    rem_nxt       = rem_r;
    rec_start_nxt = rec_start_r;
    pos_nxt       = pos_r;
    res_valid     = 1'b0;
    res.status        = crc_frc_pkg::ST_OK;
    res.record_offset = rec_start_ext[39:0];
    res.body_length   = '0;
    res.computed_crc  = '0;

    if (in_fire) begin
      if (in_end_of_log) begin
        if (phase_r == PH_HEADER && hcnt_r == 4'd0) begin
          res_valid  = 1'b1;
          res.status = crc_frc_pkg::ST_CLEAN_END;
        end else if (phase_r != PH_STOP) begin
          res_valid  = 1'b1;
          res.status = crc_frc_pkg::ST_TORN;
        end
        phase_nxt     = PH_HEADER;
        hcnt_nxt      = 4'd0;
        hdr_nxt       = '0;
        crc_nxt       = crc_frc_pkg::CRC_INIT;
        rem_nxt       = '0;
        rec_start_nxt = '0;
        pos_nxt       = '0;
      end else if (phase_r != PH_STOP) begin
        pos_nxt = pos_r + 1'b1;
        if (phase_r == PH_HEADER) begin
          hdr_nxt  = hdr_shift;
          hcnt_nxt = hcnt_r + 4'd1;
          if (hcnt_r == 4'd15) begin
            if (hdr_bad) begin
              res_valid       = 1'b1;
              res.status      = crc_frc_pkg::ST_BAD_HDR;
              res.body_length = (hdr_len > 32'(crc_frc_pkg::LEN_SAT)) ?
                                crc_frc_pkg::LEN_SAT : hdr_len[LW-1:0];
              phase_nxt       = PH_STOP;
            end else begin
              phase_nxt = PH_BODY;
              rem_nxt   = hdr_len[LW-1:0];
              crc_nxt   = crc_frc_pkg::CRC_INIT;
            end
          end
        end else begin
          crc_nxt = crc_step;
          rem_nxt = rem_r - 1'b1;
          if (rem_r == LW'(1)) begin
            res_valid        = 1'b1;
            res.body_length  = hdr_r[64 +: LW];
            res.computed_crc = crc_fin;
            if (crc_fin != hdr_r[127:96]) begin
              res.status = crc_frc_pkg::ST_CRC_FAIL;
              phase_nxt  = PH_STOP;
            end else begin
              res.status    = crc_frc_pkg::ST_OK;
              rec_start_nxt = pos_r + 1'b1;
              phase_nxt     = PH_HEADER;
              hcnt_nxt      = 4'd0;
              hdr_nxt       = '0;
              crc_nxt       = crc_frc_pkg::CRC_INIT;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hcnt_r      <= 4'd0;
      hdr_r       <= '0;
      crc_r       <= crc_frc_pkg::CRC_INIT;
      rem_r       <= '0;
      rec_start_r <= '0;
      pos_r       <= '0;
    end else begin
      phase_r     <= phase_nxt;
      hcnt_r      <= hcnt_nxt;
      hdr_r       <= hdr_nxt;
      crc_r       <= crc_nxt;
      rem_r       <= rem_nxt;
      rec_start_r <= rec_start_nxt;
      pos_r       <= pos_nxt;
    end
  end

  crc_frc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .skid_full (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_record_offset = out_res.record_offset;
  assign out_body_length   = out_res.body_length;
  assign out_computed_crc  = out_res.computed_crc;

endmodule

### src/crc_frc_checker.sv
// Port-level checks for the CRC-framed record checker, bound to the top level.
// Depends on crc_frc_pkg (status codes) and crc_framed_record_checker_core.
module crc_frc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [20:0] out_body_length,
  input logic [31:0] out_computed_crc
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // end-of-log results carry no length and no checksum
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == crc_frc_pkg::ST_TORN || out_status == crc_frc_pkg::ST_CLEAN_END)
    |-> out_body_length == 21'd0 && out_computed_crc == 32'd0)
    else $error("end status with nonzero length or crc");

  // a rejected header reports no computed checksum
  a_bad_hdr_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == crc_frc_pkg::ST_BAD_HDR |-> out_computed_crc == 32'd0)
    else $error("bad header with nonzero crc");

  // good and CRC-failed records always have a body within the hard cap
  a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == crc_frc_pkg::ST_OK || out_status == crc_frc_pkg::ST_CRC_FAIL)
    |-> out_body_length != 21'd0 && out_body_length <= crc_frc_pkg::LEN_CAP)
    else $error("record body length out of range");

endmodule

bind crc_framed_record_checker_core crc_frc_checker u_crc_frc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_body_length  (out_body_length),
  .out_computed_crc (out_computed_crc)
);
